// ===== hw/rtl/hss_pkg.sv =====
// shared types, constants and helpers of the heat stencil step unit
package hss_pkg;

  localparam int TEMP_W    = 30;
  localparam int FRAC_W    = 16;
  localparam int COEF_W    = 16;
  localparam int EDGE_W    = 14;
  localparam int DIM_W     = 9;
  localparam int IDX_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIM_MIN   = 3;
  localparam int WIN_CELLS = 2;

  // arithmetic widths of the update datapath
  localparam int DIFF_W  = TEMP_W + 2;
  localparam int PROD_W  = COEF_W + 1 + DIFF_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int DELTA_W = SUM_W - FRAC_W;
  localparam int RES_W   = DELTA_W + 1;
  localparam int ROUND_HALF = 1 << (FRAC_W - 1);

  typedef logic [TEMP_W-1:0] temp_t;
  typedef logic [EDGE_W-1:0] edge_t;
  typedef logic [COEF_W-1:0] coef_t;
  typedef logic [DIM_W-1:0]  dim_t;

  localparam temp_t TEMP_MAX = {TEMP_W{1'b1}};

  localparam dim_t  GRID_COLS_RESET   = 9'd256;
  localparam dim_t  GRID_ROWS_RESET   = 9'd256;
  localparam coef_t COEF_X_RESET      = 16'd0;
  localparam coef_t COEF_Y_RESET      = 16'd0;
  localparam edge_t EDGE_TOP_RESET    = 14'd1000;
  localparam edge_t EDGE_BOTTOM_RESET = 14'd273;
  localparam edge_t EDGE_LEFT_RESET   = 14'd1000;
  localparam edge_t EDGE_RIGHT_RESET  = 14'd273;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_COLS   = 3'd0,
    REG_GRID_ROWS   = 3'd1,
    REG_COEF_X      = 3'd2,
    REG_COEF_Y      = 3'd3,
    REG_EDGE_TOP    = 3'd4,
    REG_EDGE_BOTTOM = 3'd5,
    REG_EDGE_LEFT   = 3'd6,
    REG_EDGE_RIGHT  = 3'd7
  } cfg_reg_e;

  // one line store entry: previous row and the row before it
  typedef struct packed {
    temp_t p;
    temp_t pp;
  } pair_t;

  typedef struct packed {
    temp_t n;
    temp_t s;
    temp_t w;
    temp_t e;
    temp_t c;
  } win_t;

  // per item bookkeeping that rides along the update pipeline
  typedef struct packed {
    logic             has_a;
    logic             has_b;
    logic             a_edge;
    logic             a_run_last;
    logic             frame_last;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row_a;
    logic [IDX_W-1:0] row_b;
    temp_t            a_edge_val;
    temp_t            b_val;
  } meta_t;

  function automatic temp_t edge_q(input edge_t e);
    return {e, {FRAC_W{1'b0}}};
  endfunction

endpackage

// ===== hw/rtl/hss_ram.sv =====
// generic simple dual-port ram with registered read
module hss_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/hss_cell.sv =====
// one window cell: holds a line store entry and passes it on to its neighbour
module hss_cell
  import hss_pkg::*;
(
  input  logic  clk,
  input  logic  shift,
  input  pair_t din,
  output pair_t dout
);

  pair_t held;

  always_ff @(posedge clk) begin
    if (shift) begin
      held <= din;
    end
  end

  assign dout = held;

endmodule

// ===== hw/rtl/hss_update.sv =====
// pipelined five point update: differences, products, rounding, saturation
module hss_update
  import hss_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  win_t  win,
  input  meta_t meta_in,
  input  coef_t coef_x,
  input  coef_t coef_y,
  output logic  out_valid,
  input  logic  out_stall,
  output temp_t res,
  output meta_t meta_out
);

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  logic signed [DIFF_W-1:0]  dx1, dy1;
  temp_t                     c1, c2, c3;
  meta_t                     m1, m2, m3, m4;
  logic signed [PROD_W-1:0]  px2, py2;
  logic signed [DELTA_W-1:0] d3;
  temp_t                     r4;

  logic [DIFF_W-1:0]        dx_u, dy_u;
  logic signed [SUM_W-1:0]  sum3;
  logic signed [RES_W-1:0]  rr;
  temp_t                    sat;

  assign rdy4 = !v4 || !out_stall;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  assign dx_u = DIFF_W'(win.e) + DIFF_W'(win.w) - DIFF_W'({win.c, 1'b0});
  assign dy_u = DIFF_W'(win.n) + DIFF_W'(win.s) - DIFF_W'({win.c, 1'b0});

  // floor of (sum + half) in units of the fraction
  assign sum3 = SUM_W'(px2) + SUM_W'(py2) + SUM_W'(ROUND_HALF);

  assign rr = $signed({{(RES_W-TEMP_W){1'b0}}, c3}) + RES_W'(d3);

  always_comb begin
    priority if (rr[RES_W-1]) begin
      sat = '0;
    end else if (|rr[RES_W-2:TEMP_W]) begin
      sat = TEMP_MAX;
    end else begin
      sat = rr[TEMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      dx1 <= dx_u;
      dy1 <= dy_u;
      c1  <= win.c;
      m1  <= meta_in;
    end
    if (rdy2) begin
      px2 <= $signed({1'b0, coef_x}) * dx1;
      py2 <= $signed({1'b0, coef_y}) * dy1;
      c2  <= c1;
      m2  <= m1;
    end
    if (rdy3) begin
      d3 <= sum3[SUM_W-1:FRAC_W];
      c3 <= c2;
      m3 <= m2;
    end
    if (rdy4) begin
      r4 <= sat;
      m4 <= m3;
    end
  end

  assign out_valid = v4;
  assign res       = r4;
  assign meta_out  = m4;

endmodule

// ===== hw/rtl/heat_stencil_step_unit.sv =====
// top level of the heat stencil step unit: counters, line store, window cells, result port
//
// Takes one cell temperature per cycle in raster order while in_stall is low and
// returns the next-step temperature of the cell one row above, so results lag the
// input by one row; inputs of the bottom row also return that row's boundary value,
// and both results of such an input leave one after the other through the single
// output port. The line store is one ram of MAX_COLS entries, each holding a column
// of the two previous rows; it is read one column ahead and written one column
// behind, so one read and one write port suffice. Two window cells shifted on every
// item provide the west and centre neighbours. Store contents are undefined after
// reset and need no clearing pass. Grid size and coefficients are to be written only
// while the unit is idle; the unit itself does not enforce this.
module heat_stencil_step_unit
  import hss_pkg::*;
#(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [TEMP_W-1:0]     cell_temp,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [TEMP_W-1:0]     next_temp,
  output logic [IDX_W-1:0]      out_col,
  output logic [IDX_W-1:0]      out_row,
  output logic                  run_last,
  output logic                  frame_last
);

  localparam int CW   = $clog2(MAX_COLS);
  localparam int RW   = $clog2(MAX_ROWS);
  localparam int NCW  = $clog2(MAX_COLS + 1);
  localparam int NRW  = $clog2(MAX_ROWS + 1);
  localparam int CMPC = (NCW > DIM_W) ? NCW : DIM_W;
  localparam int CMPR = (NRW > DIM_W) ? NRW : DIM_W;

  // configuration
  dim_t  grid_cols, grid_rows;
  coef_t coef_x, coef_y;
  edge_t edge_top, edge_bottom, edge_left, edge_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols   <= GRID_COLS_RESET;
      grid_rows   <= GRID_ROWS_RESET;
      coef_x      <= COEF_X_RESET;
      coef_y      <= COEF_Y_RESET;
      edge_top    <= EDGE_TOP_RESET;
      edge_bottom <= EDGE_BOTTOM_RESET;
      edge_left   <= EDGE_LEFT_RESET;
      edge_right  <= EDGE_RIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_GRID_COLS:   grid_cols   <= cfg_data[DIM_W-1:0];
        REG_GRID_ROWS:   grid_rows   <= cfg_data[DIM_W-1:0];
        REG_COEF_X:      coef_x      <= cfg_data[COEF_W-1:0];
        REG_COEF_Y:      coef_y      <= cfg_data[COEF_W-1:0];
        REG_EDGE_TOP:    edge_top    <= cfg_data[EDGE_W-1:0];
        REG_EDGE_BOTTOM: edge_bottom <= cfg_data[EDGE_W-1:0];
        REG_EDGE_LEFT:   edge_left   <= cfg_data[EDGE_W-1:0];
        REG_EDGE_RIGHT:  edge_right  <= cfg_data[EDGE_W-1:0];
      endcase
    end
  end

  // clamped grid size
  logic [CMPC-1:0] gc_ext;
  logic [CMPR-1:0] gr_ext;
  logic [NCW-1:0]  cols_lim;
  logic [NRW-1:0]  rows_lim;

  assign gc_ext = CMPC'(grid_cols);
  assign gr_ext = CMPR'(grid_rows);

  always_comb begin
    priority if (gc_ext < CMPC'(DIM_MIN)) begin
      cols_lim = NCW'(DIM_MIN);
    end else if (gc_ext > CMPC'(MAX_COLS)) begin
      cols_lim = NCW'(MAX_COLS);
    end else begin
      cols_lim = NCW'(gc_ext);
    end
  end

  always_comb begin
    priority if (gr_ext < CMPR'(DIM_MIN)) begin
      rows_lim = NRW'(DIM_MIN);
    end else if (gr_ext > CMPR'(MAX_ROWS)) begin
      rows_lim = NRW'(MAX_ROWS);
    end else begin
      rows_lim = NRW'(gr_ext);
    end
  end

  // raster counters
  logic [CW-1:0] col_count, col_next, c_eff;
  logic [RW-1:0] row_count, row_next, r_eff;
  logic          restart, c_last, r_last;
  logic          in_acc;

  assign restart = (NCW'(col_count) >= cols_lim) || (NRW'(row_count) >= rows_lim);
  assign c_eff   = restart ? '0 : col_count;
  assign r_eff   = restart ? '0 : row_count;
  assign c_last  = NCW'(c_eff) == cols_lim - NCW'(1);
  assign r_last  = NRW'(r_eff) == rows_lim - NRW'(1);
  assign col_next = c_last ? '0 : c_eff + CW'(1);
  assign row_next = r_last ? '0 : r_eff + RW'(1);

  assign in_acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_acc) begin
      col_count <= col_next;
      row_count <= c_last ? row_next : r_eff;
    end
  end

  // stage one: accepted item, line store read lands alongside
  logic          s1_valid;
  temp_t         s1_x;
  logic [CW-1:0] s1_col;
  logic [RW-1:0] s1_row;
  logic          s1_has_a, s1_bottom, s1_first, s1_last, s1_second;
  logic          s1_adv;
  logic          upd_stall;

  assign in_stall = s1_valid && upd_stall;
  assign s1_adv   = s1_valid && !upd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_x      <= cell_temp;
      s1_col    <= c_eff;
      s1_row    <= r_eff;
      s1_has_a  <= r_eff != '0;
      s1_bottom <= r_last;
      s1_first  <= c_eff == '0;
      s1_last   <= c_last;
      s1_second <= r_eff == RW'(1);
    end
  end

  // line store, read one column ahead of the incoming item
  pair_t ram_q;
  pair_t cell_q [WIN_CELLS];
  pair_t ram_wdata;

  assign ram_wdata = '{p: s1_x, pp: cell_q[0].p};

  hss_ram #(
    .WIDTH ($bits(pair_t)),
    .DEPTH (MAX_COLS)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (col_next),
    .rdata (ram_q)
  );

  // window cells: cell 0 holds the centre column, cell 1 the west column
  genvar k;
  generate
    for (k = 0; k < WIN_CELLS; k++) begin : g_cell
      pair_t din;
      if (k == 0) begin : g_head
        assign din = ram_q;
      end else begin : g_tail
        assign din = cell_q[k-1];
      end
      hss_cell u_cell (
        .clk   (clk),
        .shift (s1_adv),
        .din   (din),
        .dout  (cell_q[k])
      );
    end
  endgenerate

  win_t  win;
  meta_t s1_meta;

  assign win = '{n: cell_q[0].pp, s: s1_x, w: cell_q[1].p, e: ram_q.p, c: cell_q[0].p};

  always_comb begin
    s1_meta            = '0;
    s1_meta.has_a      = s1_has_a;
    s1_meta.has_b      = s1_bottom;
    s1_meta.a_edge     = s1_second || s1_first || s1_last;
    s1_meta.a_run_last = !s1_bottom;
    s1_meta.frame_last = s1_bottom && s1_last;
    s1_meta.col        = IDX_W'(s1_col);
    s1_meta.row_a      = IDX_W'(s1_row - RW'(1));
    s1_meta.row_b      = IDX_W'(s1_row);
    // left and right win at the corners
    priority if (s1_first) begin
      s1_meta.a_edge_val = edge_q(edge_left);
      s1_meta.b_val      = edge_q(edge_left);
    end else if (s1_last) begin
      s1_meta.a_edge_val = edge_q(edge_right);
      s1_meta.b_val      = edge_q(edge_right);
    end else begin
      s1_meta.a_edge_val = edge_q(edge_top);
      s1_meta.b_val      = edge_q(edge_bottom);
    end
  end

  logic  upd_valid;
  logic  e_stall;
  temp_t upd_res;
  meta_t upd_meta;

  hss_update u_update (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_stall  (upd_stall),
    .win       (win),
    .meta_in   (s1_meta),
    .coef_x    (coef_x),
    .coef_y    (coef_y),
    .out_valid (upd_valid),
    .out_stall (e_stall),
    .res       (upd_res),
    .meta_out  (upd_meta)
  );

  // result register: one or two results per item
  logic  e_valid, e_phase;
  temp_t e_res;
  meta_t e_meta;
  logic  sel_b, out_acc, e_done;

  assign sel_b   = !e_meta.has_a || e_phase;
  assign out_acc = out_valid && !out_stall;
  assign e_done  = out_acc && (sel_b || !e_meta.has_b);
  assign e_stall = e_valid && !e_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      e_phase <= 1'b0;
    end else if (!e_stall) begin
      // items of the top row carry no result and drop out here
      e_valid <= upd_valid && (upd_meta.has_a || upd_meta.has_b);
      e_phase <= 1'b0;
    end else if (out_acc) begin
      e_phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!e_stall) begin
      e_res  <= upd_res;
      e_meta <= upd_meta;
    end
  end

  assign out_valid  = e_valid;
  assign next_temp  = sel_b ? e_meta.b_val : (e_meta.a_edge ? e_meta.a_edge_val : e_res);
  assign out_col    = e_meta.col;
  assign out_row    = sel_b ? e_meta.row_b : e_meta.row_a;
  assign run_last   = sel_b ? 1'b1 : e_meta.a_run_last;
  assign frame_last = sel_b && e_meta.frame_last;

  a_held_has_result: assert property (@(posedge clk) disable iff (rst)
    e_valid |-> (e_meta.has_a || e_meta.has_b))
    else $error("result register holds an item without results");

  a_second_only_bottom: assert property (@(posedge clk) disable iff (rst)
    e_valid && e_phase |-> (e_meta.has_a && e_meta.has_b))
    else $error("second result shown for an item that has only one");

  a_frame_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> run_last && (out_row == e_meta.row_b))
    else $error("frame end flagged on a result that is not the last of its item");

endmodule
